>>> design/iotq_pkg.sv
// ----------------------------------------------------------------------------
// Interval overlap query package
// Sizes, node word and frame types, and small helpers shared by the block.
// ----------------------------------------------------------------------------
package iotq_pkg;

  localparam int MAX_NOTES    = 64;
  localparam int TIME_BITS    = 40;
  localparam int IDX_BITS     = $clog2(MAX_NOTES);
  localparam int CNT_BITS     = $clog2(MAX_NOTES + 1);
  localparam int STACK_DEPTH  = IDX_BITS + 1;
  localparam int STK_IDX_BITS = $clog2(STACK_DEPTH);
  localparam int SP_BITS      = $clog2(STACK_DEPTH + 1);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // One stored interval together with the largest end of the subtree rooted at it.
  typedef struct packed {
    time_t note_start;
    time_t note_end;
    time_t max_end;
  } node_word_t;

  // A subtree is the index range [lo, hi); its root is the middle element.
  typedef struct packed {
    cnt_t lo;
    cnt_t hi;
    logic right_done;
  } frame_t;

  typedef struct packed {
    logic       rd_en;
    idx_t       rd_addr;
    logic       wr_en;
    idx_t       wr_addr;
    node_word_t wr_data;
  } ram_req_t;

  function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi);
    logic [CNT_BITS:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[CNT_BITS:1];
  endfunction

  function automatic time_t time_max(input time_t a, input time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> design/iotq_if.sv
// ----------------------------------------------------------------------------
// Interval overlap query channels
// Valid/ready interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface iotq_in_if import iotq_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  time_t note_start;
  time_t note_end;
  logic  load_last;
  time_t window_start;
  time_t window_end;

  modport source (output valid, kind, note_start, note_end, load_last,
                  window_start, window_end, input ready);
  modport sink (input valid, kind, note_start, note_end, load_last,
                window_start, window_end, output ready);
endinterface

interface iotq_out_if import iotq_pkg::*; ();
  logic valid;
  logic ready;
  idx_t match_index;
  logic none_found;
  logic last;

  modport source (output valid, match_index, none_found, last, input ready);
  modport sink (input valid, match_index, none_found, last, output ready);
endinterface

>>> design/interval_overlap_query_tree.sv
// ----------------------------------------------------------------------------
// Interval overlap query tree
// Stores sorted intervals, builds an implicit balanced max-end tree and
// answers window overlap queries with a pruned in-order walk.
// ----------------------------------------------------------------------------
// A load beat is taken only while the block is idle. The last load of a set
// starts a build that visits every node once in post order, limited by the
// single read port of the node memory. A match leaves when the next match is
// found or the walk ends, and a full output register stalls the walk. Reset
// clears all control state; the node memory is only read at entries the set wrote.
module interval_overlap_query_tree import iotq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  iotq_in_if.sink    in_i,
  iotq_out_if.source out_o
);

  // The tree is implicit: a node is an index range [lo, hi) and its root is
  // the middle index, so the node memory is addressed by interval index and
  // holds the subtree maximum end next to the interval itself.
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_BENTER = 13'b0000000000010,
    S_BRET   = 13'b0000000000100,
    S_C0     = 13'b0000000001000,
    S_C1     = 13'b0000000010000,
    S_C2     = 13'b0000000100000,
    S_C3     = 13'b0000001000000,
    S_C4     = 13'b0000010000000,
    S_QENTER = 13'b0000100000000,
    S_QCHECK = 13'b0001000000000,
    S_QPOP   = 13'b0010000000000,
    S_QVISIT = 13'b0100000000000,
    S_QFIN   = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  frame_t     cur_q, cur_d;
  logic [SP_BITS-1:0] sp_q, sp_d;
  frame_t     stack_q [STACK_DEPTH];
  cnt_t       count_q, count_d;
  logic       set_done_q, set_done_d;
  logic       tree_q, tree_d;
  time_t      ws_q, ws_d, we_q, we_d;
  time_t      acc_q, acc_d;
  node_word_t self_q, self_d;
  logic       pend_valid_q, pend_valid_d;
  idx_t       pend_idx_q, pend_idx_d;
  logic       out_valid_q, out_valid_d;
  idx_t       out_idx_q, out_idx_d;
  logic       out_none_q, out_none_d;
  logic       out_last_q, out_last_d;

  ram_req_t   ram_req;
  node_word_t rd_data;

  logic       stk_push, stk_flag;
  frame_t     push_data;
  logic [SP_BITS-1:0] top_ptr;
  frame_t     top;
  cnt_t       cur_mid, top_mid;
  logic       out_free;

  iotq_node_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  assign top_ptr  = SP_BITS'(sp_q - 1'b1);
  assign top      = stack_q[top_ptr[STK_IDX_BITS-1:0]];
  assign cur_mid  = mid_of(cur_q.lo, cur_q.hi);
  assign top_mid  = mid_of(top.lo, top.hi);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.match_index = out_idx_q;
  assign out_o.none_found  = out_none_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    cnt_t base;
    cnt_t next_cnt;
    logic hit;
    state_d      = state_q;
    cur_d        = cur_q;
    sp_d         = sp_q;
    count_d      = count_q;
    set_done_d   = set_done_q;
    tree_d       = tree_q;
    ws_d         = ws_q;
    we_d         = we_q;
    acc_d        = acc_q;
    self_d       = self_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_idx_d    = out_idx_q;
    out_none_d   = out_none_q;
    out_last_d   = out_last_q;
    ram_req      = '0;
    stk_push     = 1'b0;
    stk_flag     = 1'b0;
    push_data    = cur_q;
    base         = set_done_q ? '0 : count_q;
    next_cnt     = base;
    hit          = (rd_data.note_start <= we_q) && (rd_data.note_end >= ws_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.kind == KIND_LOAD) begin
            if (set_done_q) begin
              set_done_d = 1'b0;
              tree_d     = 1'b0;
            end
            // A load into a full store is dropped, but its last mark still counts.
            if (base < cnt_t'(MAX_NOTES)) begin
              ram_req.wr_en              = 1'b1;
              ram_req.wr_addr            = base[IDX_BITS-1:0];
              ram_req.wr_data.note_start = in_i.note_start;
              ram_req.wr_data.note_end   = in_i.note_end;
              next_cnt                   = base + 1'b1;
            end
            count_d = next_cnt;
            if (in_i.load_last) begin
              set_done_d = 1'b1;
              tree_d     = 1'b1;
              cur_d      = '{lo: '0, hi: next_cnt, right_done: 1'b0};
              state_d    = S_BENTER;
            end
          end else begin
            ws_d = in_i.window_start;
            we_d = in_i.window_end;
            if (tree_q && (in_i.window_end >= in_i.window_start)) begin
              cur_d   = '{lo: '0, hi: count_q, right_done: 1'b0};
              state_d = S_QENTER;
            end else begin
              state_d = S_QFIN;
            end
          end
        end
      end

      // Build: descend left through inner nodes, combine on the way back up.
      S_BENTER: begin
        if (cnt_t'(cur_q.hi - cur_q.lo) == cnt_t'(1)) begin
          state_d = S_C0;
        end else begin
          stk_push  = 1'b1;
          push_data = '{lo: cur_q.lo, hi: cur_q.hi, right_done: 1'b0};
          sp_d      = sp_q + 1'b1;
          cur_d     = '{lo: cur_q.lo, hi: cur_mid, right_done: 1'b0};
        end
      end

      S_BRET: begin
        if (sp_q == '0) begin
          state_d = S_IDLE;
        end else if (!top.right_done && (cnt_t'(top_mid + 1'b1) < top.hi)) begin
          stk_flag = 1'b1;
          cur_d    = '{lo: cnt_t'(top_mid + 1'b1), hi: top.hi, right_done: 1'b0};
          state_d  = S_BENTER;
        end else begin
          sp_d    = top_ptr;
          cur_d   = top;
          state_d = S_C0;
        end
      end

      S_C0: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cur_mid[IDX_BITS-1:0];
        state_d         = S_C1;
      end

      S_C1: begin
        self_d = rd_data;
        acc_d  = rd_data.note_end;
        if (cur_q.lo < cur_mid) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_t'(mid_of(cur_q.lo, cur_mid));
          state_d         = S_C2;
        end else begin
          state_d = S_C4;
        end
      end

      S_C2: begin
        acc_d = time_max(acc_q, rd_data.max_end);
        if (cnt_t'(cur_mid + 1'b1) < cur_q.hi) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_t'(mid_of(cnt_t'(cur_mid + 1'b1), cur_q.hi));
          state_d         = S_C3;
        end else begin
          state_d = S_C4;
        end
      end

      S_C3: begin
        acc_d   = time_max(acc_q, rd_data.max_end);
        state_d = S_C4;
      end

      S_C4: begin
        ram_req.wr_en              = 1'b1;
        ram_req.wr_addr            = cur_mid[IDX_BITS-1:0];
        ram_req.wr_data.note_start = self_q.note_start;
        ram_req.wr_data.note_end   = self_q.note_end;
        ram_req.wr_data.max_end    = acc_q;
        state_d                    = S_BRET;
      end

      // Query: in-order walk; the stack holds nodes whose own visit and right side are pending.
      S_QENTER: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cur_mid[IDX_BITS-1:0];
        state_d         = S_QCHECK;
      end

      S_QCHECK: begin
        if (rd_data.max_end < ws_q) begin
          state_d = S_QPOP;
        end else if (cur_q.lo < cur_mid) begin
          stk_push  = 1'b1;
          push_data = '{lo: cur_q.lo, hi: cur_q.hi, right_done: 1'b0};
          sp_d      = sp_q + 1'b1;
          cur_d     = '{lo: cur_q.lo, hi: cur_mid, right_done: 1'b0};
          state_d   = S_QENTER;
        end else begin
          state_d = S_QVISIT;
        end
      end

      S_QPOP: begin
        if (sp_q == '0) begin
          state_d = S_QFIN;
        end else begin
          sp_d            = top_ptr;
          cur_d           = top;
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = top_mid[IDX_BITS-1:0];
          state_d         = S_QVISIT;
        end
      end

      // A match is held back one step so that the final one can carry last.
      S_QVISIT: begin
        if (!hit || !pend_valid_q || out_free) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_idx_d   = pend_idx_q;
              out_none_d  = 1'b0;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = cur_mid[IDX_BITS-1:0];
          end
          if ((cnt_t'(cur_mid + 1'b1) < cur_q.hi) && (rd_data.note_start <= we_q)) begin
            cur_d   = '{lo: cnt_t'(cur_mid + 1'b1), hi: cur_q.hi, right_done: 1'b0};
            state_d = S_QENTER;
          end else begin
            state_d = S_QPOP;
          end
        end
      end

      S_QFIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = pend_valid_q ? pend_idx_q : '0;
          out_none_d   = !pend_valid_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sp_q         <= '0;
      count_q      <= '0;
      set_done_q   <= 1'b1;
      tree_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sp_q         <= sp_d;
      count_q      <= count_d;
      set_done_q   <= set_done_d;
      tree_q       <= tree_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    ws_q       <= ws_d;
    we_q       <= we_d;
    acc_q      <= acc_d;
    self_q     <= self_d;
    pend_idx_q <= pend_idx_d;
    out_idx_q  <= out_idx_d;
    out_none_q <= out_none_d;
    out_last_q <= out_last_d;
    if (stk_push) begin
      stack_q[sp_q[STK_IDX_BITS-1:0]] <= push_data;
    end
    if (stk_flag) begin
      stack_q[top_ptr[STK_IDX_BITS-1:0]].right_done <= 1'b1;
    end
  end

  // The walk stack never grows past the tree height.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_BITS'(STACK_DEPTH))
    else $error("walk stack overflow");

  // An empty answer is always the only and final beat of its query.
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.none_found |-> out_o.last)
    else $error("none_found beat without last");

  // No match is left pending once the block is idle again.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("pending match left behind");

  // The store count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MAX_NOTES))
    else $error("stored count beyond capacity");

  // Every subtree that the walk enters is nonempty.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QENTER || state_q == S_BENTER) |-> cur_q.lo < cur_q.hi)
    else $error("empty subtree entered");

endmodule

>>> design/iotq_node_ram.sv
// ----------------------------------------------------------------------------
// Interval overlap query node memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iotq_node_ram import iotq_pkg::*; (
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output node_word_t rd_data_o
);

  node_word_t mem [MAX_NOTES];
  node_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule
